[rtl/mrcl_pkg.sv]
// Shared types, constants and helpers for the motor ramp and current limit block.
package mrcl_pkg;

   localparam int MS_W   = 32;
   localparam int SPD_W  = 16;
   localparam int ADC_W  = 10;
   localparam int DUTY_W = 8;
   localparam int STEP_W = 8;
   localparam int PER_W  = 16;
   localparam int LIM_W  = 16;
   localparam int GAIN_W = 8;
   localparam int MA_W   = 16;
   localparam int CNT_W  = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;

   // last bit index of each serial pass
   localparam logic [CNT_W-1:0] TIME_LAST = 5'd31;
   localparam logic [CNT_W-1:0] DIV_LAST  = 5'd15;
   localparam logic [CNT_W-1:0] MUL_LAST  = 5'd23;
   localparam logic [CNT_W-1:0] FOLD_LAST = 5'd15;
   localparam logic [CNT_W-1:0] RAMP_LAST = 5'd17;

   localparam logic [1:0] REQ_SET   = 2'd0;
   localparam logic [1:0] REQ_BRAKE = 2'd1;
   localparam logic [1:0] REQ_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUR_LIMIT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_GAIN  = 2'd3;

   localparam logic [STEP_W-1:0] RAMP_STEP_RST   = 8'd2;
   localparam logic [PER_W-1:0]  RAMP_PERIOD_RST = 16'd100;
   localparam logic [LIM_W-1:0]  CUR_LIMIT_RST   = 16'd10000;
   localparam logic [GAIN_W-1:0] LIMIT_GAIN_RST  = 8'd26;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_TIME  = 8'b0000_0010,
      ST_DIV   = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_FOLD  = 8'b0001_0000,
      ST_RAMP  = 8'b0010_0000,
      ST_DRIVE = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      state_type            state;
      logic [CNT_W-1:0]     cnt;
      logic                 last;
   } ctrl_type;

   typedef struct packed {
      logic                    set_goal;
      logic                    brake;
      logic                    tick;
      logic signed [SPD_W-1:0] target;
      logic [ADC_W-1:0]        adc;
   } cmd_type;

   typedef struct packed {
      logic signed [SPD_W-1:0] goal_speed;
      logic signed [SPD_W-1:0] present_speed;
      logic [DUTY_W-1:0]       pwm_duty;
      logic                    side_b;
      logic                    side_a;
   } rsp_type;

   // carry out of a one-bit full adder
   function automatic logic maj3(input logic x, input logic y, input logic z);
      maj3 = (x & y) | (x & z) | (y & z);
   endfunction

endpackage

[rtl/mrcl_timer.sv]
// Millisecond counter with bit-serial elapsed-time compares for the check and ramp intervals.
module mrcl_timer (
   input  logic                          clock,
   input  logic                          reset,
   input  mrcl_pkg::ctrl_type            ctrl,
   input  logic [mrcl_pkg::PER_W-1:0]    ramp_period,
   input  logic                          stepped,
   output logic                          chk,
   output logic                          due
);
   import mrcl_pkg::*;

   logic [MS_W-1:0]  ms_ff, ms_in;
   logic [MS_W-1:0]  lchk_ff, lchk_in;
   logic [MS_W-1:0]  lramp_ff, lramp_in;
   logic [PER_W-1:0] per_sr_ff, per_sr_in;
   logic prev_ff, prev_in;
   logic ci_ff, ci_in;     // increment carry
   logic c1_ff, c1_in;     // ms - last check
   logic cc_ff, cc_in;     // 2*period - elapsed
   logic c2_ff, c2_in;     // ms - last ramp
   logic cr_ff, cr_in;     // period - elapsed
   logic mn, d1, d2, p1;

   always_comb begin
      ms_in     = ms_ff;
      lchk_in   = lchk_ff;
      lramp_in  = lramp_ff;
      per_sr_in = per_sr_ff;
      prev_in   = prev_ff;
      ci_in     = ci_ff;
      c1_in     = c1_ff;
      cc_in     = cc_ff;
      c2_in     = c2_ff;
      cr_in     = cr_ff;

      mn = ms_ff[0] ^ ci_ff;
      d1 = mn ^ ~lchk_ff[0] ^ c1_ff;
      d2 = mn ^ ~lramp_ff[0] ^ c2_ff;
      p1 = per_sr_ff[0];

      unique case (ctrl.state)
         ST_IDLE: begin
            per_sr_in = ramp_period;
            prev_in   = 1'b0;
            ci_in     = 1'b1;
            c1_in     = 1'b1;
            cc_in     = 1'b1;
            c2_in     = 1'b1;
            cr_in     = 1'b1;
         end
         ST_TIME: begin
            ci_in     = ms_ff[0] & ci_ff;
            c1_in     = maj3(mn, ~lchk_ff[0], c1_ff);
            c2_in     = maj3(mn, ~lramp_ff[0], c2_ff);
            // prev holds the period bit one place down, i.e. twice the period
            cc_in     = maj3(prev_ff, ~d1, cc_ff);
            cr_in     = maj3(p1, ~d2, cr_ff);
            ms_in     = {mn, ms_ff[MS_W-1:1]};
            lchk_in   = {lchk_ff[0], lchk_ff[MS_W-1:1]};
            lramp_in  = {lramp_ff[0], lramp_ff[MS_W-1:1]};
            per_sr_in = {1'b0, per_sr_ff[PER_W-1:1]};
            prev_in   = p1;
         end
         ST_DIV: begin
            if (ctrl.cnt == '0 && !cc_ff) begin
               lchk_in = ms_ff;
            end
         end
         ST_DRIVE: begin
            if (stepped) begin
               lramp_in = ms_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ms_ff    <= '0;
         lchk_ff  <= '0;
         lramp_ff <= '0;
         prev_ff  <= 1'b0;
         ci_ff    <= 1'b1;
         c1_ff    <= 1'b1;
         cc_ff    <= 1'b1;
         c2_ff    <= 1'b1;
         cr_ff    <= 1'b1;
      end else begin
         ms_ff    <= ms_in;
         lchk_ff  <= lchk_in;
         lramp_ff <= lramp_in;
         prev_ff  <= prev_in;
         ci_ff    <= ci_in;
         c1_ff    <= c1_in;
         cc_ff    <= cc_in;
         c2_ff    <= c2_in;
         cr_ff    <= cr_in;
      end
   end

   always_ff @(posedge clock) begin
      per_sr_ff <= per_sr_in;
   end

   // no carry out of limit - elapsed means elapsed is past the limit
   assign chk = ~cc_ff;
   assign due = ~cr_ff;

endmodule

[rtl/mrcl_current.sv]
// Current path: serial divide by three to mA, serial excess and shift-add foldback product.
module mrcl_current (
   input  logic                          clock,
   input  logic                          reset,
   input  mrcl_pkg::ctrl_type            ctrl,
   input  mrcl_pkg::cmd_type             cmd,
   input  logic [mrcl_pkg::LIM_W-1:0]    current_limit,
   input  logic [mrcl_pkg::GAIN_W-1:0]   limit_gain,
   input  logic                          chk,
   output logic                          red_bit
);
   import mrcl_pkg::*;

   logic [MA_W-1:0]   n_sr_ff, n_sr_in;
   logic [1:0]        rem_ff, rem_in;
   logic [MA_W-1:0]   q_sr_ff, q_sr_in;
   logic [LIM_W-1:0]  lim_sr_ff, lim_sr_in;
   logic              sc_ff, sc_in;
   logic [GAIN_W-1:0] acc_ff, acc_in;
   logic [MA_W-1:0]   red_sr_ff, red_sr_in;
   logic [MA_W-1:0]   adc_w;
   logic [2:0]        t;
   logic              q, x;
   logic [GAIN_W:0]   s;

   always_comb begin
      n_sr_in   = n_sr_ff;
      rem_in    = rem_ff;
      q_sr_in   = q_sr_ff;
      lim_sr_in = lim_sr_ff;
      sc_in     = sc_ff;
      acc_in    = acc_ff;
      red_sr_in = red_sr_ff;

      // adc * 1000 / 60 = adc * 50 / 3
      adc_w = MA_W'(cmd.adc);
      t     = {rem_ff, n_sr_ff[MA_W-1]};
      q     = t >= 3'd3;
      x     = ~ctrl.cnt[4] & (q_sr_ff[0] ^ ~lim_sr_ff[0] ^ sc_ff);
      s     = {1'b0, acc_ff} + (x ? {1'b0, limit_gain} : '0);

      if (cmd.tick) begin
         n_sr_in = (adc_w << 5) + (adc_w << 4) + (adc_w << 1);
         rem_in  = 2'd0;
      end

      unique case (ctrl.state)
         ST_DIV: begin
            rem_in    = q ? 2'(t - 3'd3) : t[1:0];
            n_sr_in   = {n_sr_ff[MA_W-2:0], 1'b0};
            q_sr_in   = {q_sr_ff[MA_W-2:0], q};
            lim_sr_in = current_limit;
            sc_in     = 1'b1;
            acc_in    = '0;
         end
         ST_MUL: begin
            // while cnt[4] is set the accumulator is flushed with zero input
            if (!ctrl.cnt[4]) begin
               sc_in = maj3(q_sr_ff[0], ~lim_sr_ff[0], sc_ff);
            end
            q_sr_in   = {1'b0, q_sr_ff[MA_W-1:1]};
            lim_sr_in = {1'b0, lim_sr_ff[LIM_W-1:1]};
            acc_in    = s[GAIN_W:1];
            red_sr_in = {s[0], red_sr_ff[MA_W-1:1]};
         end
         ST_FOLD: begin
            red_sr_in = {1'b0, red_sr_ff[MA_W-1:1]};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
         sc_ff  <= 1'b1;
      end else begin
         rem_ff <= rem_in;
         sc_ff  <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      n_sr_ff   <= n_sr_in;
      q_sr_ff   <= q_sr_in;
      lim_sr_ff <= lim_sr_in;
      acc_ff    <= acc_in;
      red_sr_ff <= red_sr_in;
   end

   // carry set means mA >= limit; equal gives a zero product anyway
   assign red_bit = red_sr_ff[0] & sc_ff & chk;

endmodule

[rtl/mrcl_speed.sv]
// Goal and present speed: serial foldback, serial ramp step and bridge drive update.
module mrcl_speed (
   input  logic                          clock,
   input  logic                          reset,
   input  mrcl_pkg::ctrl_type            ctrl,
   input  mrcl_pkg::cmd_type             cmd,
   input  logic [mrcl_pkg::STEP_W-1:0]   ramp_step,
   input  logic                          red_bit,
   input  logic                          due,
   output logic                          stepped,
   output mrcl_pkg::rsp_type             fields
);
   import mrcl_pkg::*;

   logic [SPD_W-1:0]  goal_ff, goal_in;
   logic [SPD_W-1:0]  now_ff, now_in;
   logic              side_a_ff, side_a_in;
   logic              side_b_ff, side_b_in;
   logic [DUTY_W-1:0] duty_ff, duty_in;
   logic              gneg_ff, gneg_in;
   logic              fc_ff, fc_in;
   logic              gsign_ff, gsign_in;
   logic              nsign_ff, nsign_in;
   logic [STEP_W-1:0] step_sr_ff, step_sr_in;
   logic              c1_ff, c1_in;
   logic              ce_ff, ce_in;
   logic              cf_ff, cf_in;
   logic              ca_ff, ca_in;
   logic              cb_ff, cb_in;
   logic              neq_ff, neq_in;
   logic              fz_ff, fz_in;
   logic [SPD_W-1:0]  a_sr_ff, a_sr_in;
   logic [SPD_W-1:0]  b_sr_ff, b_sr_in;
   logic              stepped_ff, stepped_in;

   logic              fold_rb, fold_r, clamp, in16;
   logic              gb, nb, sb, d, e, f, a, b, take_goal;
   logic [SPD_W-1:0]  fold_sum, mag;
   logic              near_stop;

   always_comb begin
      goal_in    = goal_ff;
      now_in     = now_ff;
      side_a_in  = side_a_ff;
      side_b_in  = side_b_ff;
      duty_in    = duty_ff;
      gneg_in    = gneg_ff;
      fc_in      = fc_ff;
      gsign_in   = gsign_ff;
      nsign_in   = nsign_ff;
      step_sr_in = step_sr_ff;
      c1_in      = c1_ff;
      ce_in      = ce_ff;
      cf_in      = cf_ff;
      ca_in      = ca_ff;
      cb_in      = cb_ff;
      neq_in     = neq_ff;
      fz_in      = fz_ff;
      a_sr_in    = a_sr_ff;
      b_sr_in    = b_sr_ff;
      stepped_in = stepped_ff;

      // foldback: goal moves toward zero by the reduction, never across it
      fold_rb  = gneg_ff ? red_bit : ~red_bit;
      fold_r   = goal_ff[0] ^ fold_rb ^ fc_ff;
      fold_sum = {fold_r, goal_ff[SPD_W-1:1]};
      clamp    = fold_r != gneg_ff;

      // ramp: delta = goal - now, e = delta - step, f = delta + step (sign-extended)
      in16 = ~ctrl.cnt[4];
      gb   = in16 ? goal_ff[0] : gsign_ff;
      nb   = in16 ? now_ff[0] : nsign_ff;
      sb   = step_sr_ff[0];
      d    = gb ^ ~nb ^ c1_ff;
      e    = d ^ ~sb ^ ce_ff;
      f    = d ^ sb ^ cf_ff;
      a    = nb ^ sb ^ ca_ff;
      b    = nb ^ ~sb ^ cb_ff;
      // on the sign cycle: d is delta's sign, e and f the signs of e and f
      take_goal = d ? (~f & fz_ff) : e;

      mag       = now_ff[SPD_W-1] ? SPD_W'(~now_ff + 1'b1) : now_ff;
      near_stop = (now_ff == '0) || (now_ff == SPD_W'(1)) || (now_ff == '1);

      if (cmd.set_goal) begin
         goal_in = cmd.target;
      end
      if (cmd.brake) begin
         side_a_in = 1'b1;
         side_b_in = 1'b1;
         duty_in   = '0;
         now_in    = '0;
         goal_in   = '0;
      end

      unique case (ctrl.state)
         ST_MUL: begin
            gneg_in = goal_ff[SPD_W-1];
            fc_in   = ~goal_ff[SPD_W-1];
         end
         ST_FOLD: begin
            fc_in   = maj3(goal_ff[0], fold_rb, fc_ff);
            goal_in = fold_sum;
            if (ctrl.last) begin
               if (clamp) begin
                  goal_in = '0;
               end
               gsign_in   = clamp ? 1'b0 : fold_r;
               nsign_in   = now_ff[SPD_W-1];
               step_sr_in = ramp_step;
               c1_in      = 1'b1;
               ce_in      = 1'b1;
               cf_in      = 1'b0;
               ca_in      = 1'b0;
               cb_in      = 1'b1;
               neq_in     = 1'b0;
               fz_in      = 1'b0;
            end
         end
         ST_RAMP: begin
            c1_in      = maj3(gb, ~nb, c1_ff);
            ce_in      = maj3(d, ~sb, ce_ff);
            cf_in      = maj3(d, sb, cf_ff);
            ca_in      = maj3(nb, sb, ca_ff);
            cb_in      = maj3(nb, ~sb, cb_ff);
            neq_in     = neq_ff | d;
            fz_in      = fz_ff | f;
            step_sr_in = {1'b0, step_sr_ff[STEP_W-1:1]};
            if (in16) begin
               goal_in = {goal_ff[0], goal_ff[SPD_W-1:1]};
               now_in  = {now_ff[0], now_ff[SPD_W-1:1]};
               a_sr_in = {a, a_sr_ff[SPD_W-1:1]};
               b_sr_in = {b, b_sr_ff[SPD_W-1:1]};
            end
            if (ctrl.last) begin
               stepped_in = due & (neq_ff | d);
               if (due & (neq_ff | d)) begin
                  now_in = take_goal ? goal_ff : (d ? b_sr_ff : a_sr_ff);
               end
            end
         end
         ST_DRIVE: begin
            if (stepped_ff) begin
               if (near_stop) begin
                  side_a_in = 1'b1;
                  side_b_in = 1'b1;
                  duty_in   = '0;
                  now_in    = '0;
                  goal_in   = '0;
               end else begin
                  side_a_in = ~now_ff[SPD_W-1];
                  side_b_in = now_ff[SPD_W-1];
                  duty_in   = (|mag[SPD_W-1:DUTY_W]) ? '1 : mag[DUTY_W-1:0];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff    <= '0;
         now_ff     <= '0;
         side_a_ff  <= 1'b0;
         side_b_ff  <= 1'b0;
         duty_ff    <= '0;
         gneg_ff    <= 1'b0;
         fc_ff      <= 1'b0;
         gsign_ff   <= 1'b0;
         nsign_ff   <= 1'b0;
         c1_ff      <= 1'b0;
         ce_ff      <= 1'b0;
         cf_ff      <= 1'b0;
         ca_ff      <= 1'b0;
         cb_ff      <= 1'b0;
         neq_ff     <= 1'b0;
         fz_ff      <= 1'b0;
         stepped_ff <= 1'b0;
      end else begin
         goal_ff    <= goal_in;
         now_ff     <= now_in;
         side_a_ff  <= side_a_in;
         side_b_ff  <= side_b_in;
         duty_ff    <= duty_in;
         gneg_ff    <= gneg_in;
         fc_ff      <= fc_in;
         gsign_ff   <= gsign_in;
         nsign_ff   <= nsign_in;
         c1_ff      <= c1_in;
         ce_ff      <= ce_in;
         cf_ff      <= cf_in;
         ca_ff      <= ca_in;
         cb_ff      <= cb_in;
         neq_ff     <= neq_in;
         fz_ff      <= fz_in;
         stepped_ff <= stepped_in;
      end
   end

   always_ff @(posedge clock) begin
      step_sr_ff <= step_sr_in;
      a_sr_ff    <= a_sr_in;
      b_sr_ff    <= b_sr_in;
   end

   assign stepped              = stepped_ff;
   assign fields.side_a        = side_a_ff;
   assign fields.side_b        = side_b_ff;
   assign fields.pwm_duty      = duty_ff;
   assign fields.present_speed = now_ff;
   assign fields.goal_speed    = goal_ff;

endmodule

[rtl/motor_ramp_current_limit.sv]
// Top level: request sequencer, configuration registers and result register.
// Motor speed ramp with over-current foldback. Each request item gives one result item
// showing the bridge state after it. Set-target, brake and unused-code items take effect at
// once; they go straight to the done state, which loads their result into the output
// register. A tick item goes through a bit-serial datapath: the millisecond counter and
// elapsed-time compares, the divide-by-three that turns the ADC sample into mA, the
// excess-times-gain product, the goal foldback, the ramp step and the drive update, then
// the done state, which loads the result once the output register is free. One item is in
// work at a time; the next is taken the cycle after the previous result is loaded into the
// output register, which holds it until it is accepted. Configuration writes are accepted
// outside reset and should be made only while no item is in work.
module motor_ramp_current_limit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mrcl_pkg::REQ_DATA_W-1:0]    req_tdata,  // target_speed, adc_sample
   input  logic [1:0]                         req_tuser,  // req_type
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // side_a, side_b, pwm_duty, present_speed, goal_speed
   output logic [mrcl_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mrcl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mrcl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mrcl_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [STEP_W-1:0] ramp_step_ff, ramp_step_in;
   logic [PER_W-1:0]  ramp_period_ff, ramp_period_in;
   logic [LIM_W-1:0]  cur_limit_ff, cur_limit_in;
   logic [GAIN_W-1:0] limit_gain_ff, limit_gain_in;

   ctrl_type ctrl;
   cmd_type  cmd;
   rsp_type  fields;
   logic     accept, last, load_rsp;
   logic     chk, due, red_bit, stepped;

   assign req_tready = (state_ff == ST_IDLE) & ~reset;
   assign accept     = req_tvalid & req_tready;
   assign csr_ready  = ~reset;

   always_comb begin
      unique case (state_ff)
         ST_TIME: last = cnt_ff == TIME_LAST;
         ST_DIV:  last = cnt_ff == DIV_LAST;
         ST_MUL:  last = cnt_ff == MUL_LAST;
         ST_FOLD: last = cnt_ff == FOLD_LAST;
         ST_RAMP: last = cnt_ff == RAMP_LAST;
         default: last = 1'b1;
      endcase
   end

   always_comb begin
      cmd.set_goal = accept && req_tuser == REQ_SET;
      cmd.brake    = accept && req_tuser == REQ_BRAKE;
      cmd.tick     = accept && req_tuser == REQ_TICK;
      cmd.target   = req_tdata[SPD_W-1:0];
      cmd.adc      = req_tdata[SPD_W+ADC_W-1:SPD_W];
      ctrl.state   = state_ff;
      ctrl.cnt     = cnt_ff;
      ctrl.last    = last;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = cmd.tick ? ST_TIME : ST_DONE;
            end
         end
         ST_TIME:  if (last) state_in = ST_DIV;
         ST_DIV:   if (last) state_in = ST_MUL;
         ST_MUL:   if (last) state_in = ST_FOLD;
         ST_FOLD:  if (last) state_in = ST_RAMP;
         ST_RAMP:  if (last) state_in = ST_DRIVE;
         ST_DRIVE: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (last) begin
         cnt_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_DATA_W'(fields);
      end
   end

   always_comb begin
      ramp_step_in   = ramp_step_ff;
      ramp_period_in = ramp_period_ff;
      cur_limit_in   = cur_limit_ff;
      limit_gain_in  = limit_gain_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RAMP_STEP:   ramp_step_in   = csr_data[STEP_W-1:0];
            CSR_RAMP_PERIOD: ramp_period_in = csr_data[PER_W-1:0];
            CSR_CUR_LIMIT:   cur_limit_in   = csr_data[LIM_W-1:0];
            CSR_LIMIT_GAIN:  limit_gain_in  = csr_data[GAIN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         ramp_step_ff   <= RAMP_STEP_RST;
         ramp_period_ff <= RAMP_PERIOD_RST;
         cur_limit_ff   <= CUR_LIMIT_RST;
         limit_gain_ff  <= LIMIT_GAIN_RST;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         ramp_step_ff   <= ramp_step_in;
         ramp_period_ff <= ramp_period_in;
         cur_limit_ff   <= cur_limit_in;
         limit_gain_ff  <= limit_gain_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   mrcl_timer u_timer (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .ramp_period (ramp_period_ff),
      .stepped     (stepped),
      .chk         (chk),
      .due         (due)
   );

   mrcl_current u_current (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .cmd           (cmd),
      .current_limit (cur_limit_ff),
      .limit_gain    (limit_gain_ff),
      .chk           (chk),
      .red_bit       (red_bit)
   );

   mrcl_speed u_speed (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .cmd       (cmd),
      .ramp_step (ramp_step_ff),
      .red_bit   (red_bit),
      .due       (due),
      .stepped   (stepped),
      .fields    (fields)
   );

endmodule
